[hdl/clfc_pkg.sv]
// Package for the CRC-16 line frame checker: character codes, verdict codes,
// result type and the byte-wide CRC-16/CCITT-FALSE and character helpers.
// No dependencies.
package clfc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  ExpectedFieldsReset = 8'd14;

  localparam logic [7:0] ChrStar    = 8'h2A;
  localparam logic [7:0] ChrComma   = 8'h2C;
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrSpace   = 8'h20;

  localparam logic [2:0] HexMaxDigits  = 3'd4;
  localparam logic [2:0] HexOverflow   = 3'd5;
  localparam logic [7:0] CommaSatLimit = 8'd254;
  localparam logic [7:0] CountMax      = 8'd255;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_NO_STAR  = 3'd1,
    VERDICT_BAD_HEX  = 3'd2,
    VERDICT_CRC_BAD  = 3'd3,
    VERDICT_FIELDS   = 3'd4
  } verdict_e;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic [7:0]  field_count;
  } result_t;

  // One byte through CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Space, tab, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChrSpace) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

[hdl/crc16_line_frame_checker_unit.sv]
// Top level of the CRC-16 line frame checker: input register, line tracker,
// result register and the expected-fields register. Uses clfc_pkg, clfc_line_tracker.
//
//  channel   dir  payload                                       handshake
//  s_axis    in   tdata[7:0] rx_byte                            tvalid/tready
//  m_axis    out  tdata[47:0] verdict,rx crc,calc crc,fields    tvalid/tready
//  cfg       in   cfg_wdata_i[7:0] expected_fields              cfg_we_i
//
// One byte per cycle while m_axis takes its results. An accepted byte is held in
// the input register for the line tracker; its verdict (newline only) is held in
// the result register on m_axis. The byte-wide CRC update sets the critical path.
// Reset (rst_ni low, async) clears line state and sets expected_fields to 14.
// When the result register is full and not taken, the tracker holds its byte
// and s_axis_tready drops; nothing is lost or repeated.
module crc16_line_frame_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [2:0] verdict, [18:3] received_crc,
                                      // [34:19] computed_crc, [42:35] field_count,
                                      // [47:43] zero
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i     // expected_fields
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  clfc_pkg::result_t out_q;
  logic [7:0]        exp_fields_q;
  logic              fire;
  logic              emit;
  clfc_pkg::result_t result;

  // tracker advances when the result register can take a possible verdict
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_fields_q <= clfc_pkg::ExpectedFieldsReset;
    end else if (cfg_we_i) begin
      exp_fields_q <= cfg_wdata_i;
    end
  end

  clfc_line_tracker u_tracker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .byte_i            (in_byte_q),
    .expected_fields_i (exp_fields_q),
    .emit_o            (emit),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.field_count, out_q.computed_crc,
                          out_q.received_crc, out_q.verdict};

endmodule

[hdl/clfc_line_tracker.sv]
// Per-line state of the frame checker: running CRC, comma count, star snapshot
// and hex trailer parse; forms the verdict at newline. Uses clfc_pkg.
module clfc_line_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            expected_fields_i,
  output logic                  emit_o,
  output clfc_pkg::result_t     result_o
);

  logic [15:0] running_crc_q, running_crc_d;
  logic [15:0] crc_at_star_q, crc_at_star_d;
  logic [7:0]  running_commas_q, running_commas_d;
  logic [7:0]  commas_at_star_q, commas_at_star_d;
  logic        star_seen_q, star_seen_d;
  logic        line_started_q, line_started_d;
  logic [15:0] hex_value_q, hex_value_d;
  logic [2:0]  hex_digits_q, hex_digits_d;
  logic        hex_bad_q, hex_bad_d;
  logic        hex_trail_q, hex_trail_d;

  logic        is_nl, is_sp;
  logic [4:0]  nib;
  logic [7:0]  fields;

  assign is_nl  = (byte_i == clfc_pkg::ChrNewline);
  assign is_sp  = clfc_pkg::is_space(byte_i);
  assign nib    = clfc_pkg::hex_nibble(byte_i);
  assign fields = (commas_at_star_q >= clfc_pkg::CommaSatLimit) ? clfc_pkg::CountMax
                                                                 : commas_at_star_q + 8'd1;

  // verdict from the state before the newline
  always_comb begin
    result_o = '{verdict: clfc_pkg::VERDICT_NO_STAR, received_crc: 16'h0000,
                 computed_crc: 16'h0000, field_count: 8'h00};
    if (star_seen_q) begin
      result_o.computed_crc = crc_at_star_q;
      result_o.field_count  = fields;
      if (hex_bad_q || (hex_digits_q == 3'd0)) begin
        result_o.verdict = clfc_pkg::VERDICT_BAD_HEX;
      end else begin
        result_o.received_crc = hex_value_q;
        if (hex_value_q != crc_at_star_q) begin
          result_o.verdict = clfc_pkg::VERDICT_CRC_BAD;
        end else if (fields != expected_fields_i) begin
          result_o.verdict = clfc_pkg::VERDICT_FIELDS;
        end else begin
          result_o.verdict = clfc_pkg::VERDICT_OK;
        end
      end
    end
  end

  assign emit_o = fire_i && is_nl && line_started_q;

  always_comb begin
    running_crc_d    = running_crc_q;
    crc_at_star_d    = crc_at_star_q;
    running_commas_d = running_commas_q;
    commas_at_star_d = commas_at_star_q;
    star_seen_d      = star_seen_q;
    line_started_d   = line_started_q;
    hex_value_d      = hex_value_q;
    hex_digits_d     = hex_digits_q;
    hex_bad_d        = hex_bad_q;
    hex_trail_d      = hex_trail_q;
    if (fire_i) begin
      if (is_nl) begin
        running_crc_d    = clfc_pkg::CrcInit;
        crc_at_star_d    = clfc_pkg::CrcInit;
        running_commas_d = 8'd0;
        commas_at_star_d = 8'd0;
        star_seen_d      = 1'b0;
        line_started_d   = 1'b0;
        hex_value_d      = 16'h0000;
        hex_digits_d     = 3'd0;
        hex_bad_d        = 1'b0;
        hex_trail_d      = 1'b0;
      end else if (line_started_q || !is_sp) begin
        line_started_d = 1'b1;
        if (byte_i == clfc_pkg::ChrStar) begin
          crc_at_star_d    = running_crc_q;
          commas_at_star_d = running_commas_q;
          star_seen_d      = 1'b1;
          hex_value_d      = 16'h0000;
          hex_digits_d     = 3'd0;
          hex_bad_d        = 1'b0;
          hex_trail_d      = 1'b0;
        end else if (star_seen_q) begin
          if (is_sp) begin
            if (hex_digits_q == 3'd0) hex_bad_d = 1'b1;
            hex_trail_d = 1'b1;
          end else if (!nib[4] || hex_trail_q) begin
            hex_bad_d = 1'b1;
          end else if (hex_digits_q >= clfc_pkg::HexMaxDigits) begin
            hex_bad_d    = 1'b1;
            hex_digits_d = clfc_pkg::HexOverflow;
          end else begin
            hex_value_d  = {hex_value_q[11:0], nib[3:0]};
            hex_digits_d = hex_digits_q + 3'd1;
          end
        end
        if ((byte_i == clfc_pkg::ChrComma) && (running_commas_q != clfc_pkg::CountMax)) begin
          running_commas_d = running_commas_q + 8'd1;
        end
        running_crc_d = clfc_pkg::crc16_byte(running_crc_q, byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_crc_q    <= clfc_pkg::CrcInit;
      crc_at_star_q    <= clfc_pkg::CrcInit;
      running_commas_q <= 8'd0;
      commas_at_star_q <= 8'd0;
      star_seen_q      <= 1'b0;
      line_started_q   <= 1'b0;
      hex_value_q      <= 16'h0000;
      hex_digits_q     <= 3'd0;
      hex_bad_q        <= 1'b0;
      hex_trail_q      <= 1'b0;
    end else begin
      running_crc_q    <= running_crc_d;
      crc_at_star_q    <= crc_at_star_d;
      running_commas_q <= running_commas_d;
      commas_at_star_q <= commas_at_star_d;
      star_seen_q      <= star_seen_d;
      line_started_q   <= line_started_d;
      hex_value_q      <= hex_value_d;
      hex_digits_q     <= hex_digits_d;
      hex_bad_q        <= hex_bad_d;
      hex_trail_q      <= hex_trail_d;
    end
  end

  // newline always leaves a clean line
  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_nl |=> !line_started_q && !star_seen_q && (running_commas_q == 8'd0))
    else $error("line state not cleared after newline");

  a_hex_digits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_digits_q <= clfc_pkg::HexOverflow)
    else $error("hex digit count out of range");

  a_star_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (byte_i == clfc_pkg::ChrStar) |=> star_seen_q &&
      (crc_at_star_q == $past(running_crc_q)))
    else $error("star did not snapshot running CRC");

  a_overflow_is_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hex_digits_q == clfc_pkg::HexOverflow) |-> hex_bad_q)
    else $error("hex overflow without bad flag");

endmodule

[tb/crc16_line_frame_checker_unit_tb.sv]
// Self-checking testbench for crc16_line_frame_checker_unit: line framing, CRC-16,
// hex trailer parsing and field counting are predicted byte by byte and every
// verdict is compared field by field. Depends on clfc_pkg and the unit only.
`timescale 1ns / 100ps

module crc16_line_frame_checker_unit_tb;

  localparam int         CYCLE_LIMIT     = 600_000;
  localparam int         RANDOM_BYTES    = 500;
  localparam int         DRAIN_CYCLES    = 6;
  localparam int         MAX_WAIT        = 18;
  localparam int         MAX_REPORTS     = 10;
  localparam logic [7:0] FIELDS_AT_RESET = 8'd14;

  localparam logic [7:0] CHR_TAB  = 8'h09;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;
  localparam logic [7:0] CHR_A_UP = 8'h41;
  localparam logic [7:0] CHR_F_UP = 8'h46;
  localparam logic [7:0] CHR_A_LO = 8'h61;
  localparam logic [7:0] CHR_F_LO = 8'h66;
  localparam logic [7:0] CHR_DOT  = 8'h2E;
  localparam logic [7:0] CHR_DASH = 8'h2D;
  localparam logic [7:0] CHR_X_LO = 8'h78;
  localparam logic [7:0] CHR_G_UP = 8'h47;

  // Malformed trailers used by the directed and random lines
  typedef enum int {
    BRK_NO_STAR,
    BRK_EMPTY_HEX,
    BRK_LONG_HEX,
    BRK_PREFIX,
    BRK_LEAD_SPACE,
    BRK_DIGIT_AFTER_SPACE,
    BRK_COMMA_IN_HEX,
    BRK_NON_HEX
  } broken_e;

  typedef struct packed {
    clfc_pkg::verdict_e verdict;
    logic [15:0]        rx_crc;
    logic [15:0]        calc_crc;
    logic [7:0]         fields;
  } line_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  crc16_line_frame_checker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Line tracker mirror
  logic [7:0]  exp_fields;
  logic [15:0] ln_crc;
  logic [15:0] ln_crc_star;
  logic [7:0]  ln_commas;
  logic [7:0]  ln_commas_star;
  logic        ln_star;
  logic        ln_started;
  logic [15:0] ln_hex;
  logic [2:0]  ln_hex_digits;
  logic        ln_hex_bad;
  logic        ln_hex_tail;

  line_result_t verdicts_due[$];
  logic [7:0]   payload_q[$];

  int fail_count;
  int bytes_sent;
  int cycle_count;
  bit src_idle;
  bit sink_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // CRC-16/CCITT-FALSE, one input bit per step, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? clfc_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == clfc_pkg::ChrSpace) || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= CHR_ZERO && c <= CHR_NINE) return int'(c - CHR_ZERO);
    if (c >= CHR_A_UP && c <= CHR_F_UP) return int'(c - CHR_A_UP) + 10;
    if (c >= CHR_A_LO && c <= CHR_F_LO) return int'(c - CHR_A_LO) + 10;
    return -1;
  endfunction

  function automatic void clear_line_state();
    ln_crc         = clfc_pkg::CrcInit;
    ln_crc_star    = clfc_pkg::CrcInit;
    ln_commas      = '0;
    ln_commas_star = '0;
    ln_star        = 1'b0;
    ln_started     = 1'b0;
    ln_hex         = '0;
    ln_hex_digits  = '0;
    ln_hex_bad     = 1'b0;
    ln_hex_tail    = 1'b0;
  endfunction

  // Advance the mirror by one accepted byte; a newline closing a non-blank
  // line queues its verdict.
  function automatic void follow_line_byte(input logic [7:0] c);
    line_result_t r;
    int           nib;
    if (c == clfc_pkg::ChrNewline) begin
      if (ln_started) begin
        r = '{verdict: clfc_pkg::VERDICT_NO_STAR, rx_crc: '0, calc_crc: '0, fields: '0};
        if (ln_star) begin
          r.calc_crc = ln_crc_star;
          r.fields   = (ln_commas_star >= clfc_pkg::CommaSatLimit) ? clfc_pkg::CountMax
                                                                   : ln_commas_star + 8'd1;
          if (ln_hex_bad || ln_hex_digits == 0) begin
            r.verdict = clfc_pkg::VERDICT_BAD_HEX;
          end else begin
            r.rx_crc = ln_hex;
            if (ln_hex != ln_crc_star)       r.verdict = clfc_pkg::VERDICT_CRC_BAD;
            else if (r.fields != exp_fields) r.verdict = clfc_pkg::VERDICT_FIELDS;
            else                             r.verdict = clfc_pkg::VERDICT_OK;
          end
        end
        verdicts_due.push_back(r);
      end
      clear_line_state();
      return;
    end
    if (!ln_started) begin
      if (blank_char(c)) return;
      ln_started = 1'b1;
    end
    if (c == clfc_pkg::ChrStar) begin
      ln_crc_star    = ln_crc;
      ln_commas_star = ln_commas;
      ln_star        = 1'b1;
      ln_hex         = '0;
      ln_hex_digits  = '0;
      ln_hex_bad     = 1'b0;
      ln_hex_tail    = 1'b0;
    end else if (ln_star) begin
      nib = hex_digit_value(c);
      if (blank_char(c)) begin
        if (ln_hex_digits == 0) ln_hex_bad = 1'b1;
        ln_hex_tail = 1'b1;
      end else if (nib < 0 || ln_hex_tail) begin
        ln_hex_bad = 1'b1;
      end else if (ln_hex_digits >= clfc_pkg::HexMaxDigits) begin
        ln_hex_bad    = 1'b1;
        ln_hex_digits = clfc_pkg::HexOverflow;
      end else begin
        ln_hex        = {ln_hex[11:0], 4'(nib)};
        ln_hex_digits = ln_hex_digits + 3'd1;
      end
    end
    if (c == clfc_pkg::ChrComma && ln_commas != clfc_pkg::CountMax) ln_commas = ln_commas + 8'd1;
    ln_crc = crc_ccitt_step(ln_crc, c);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the byte.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    bytes_sent++;
    follow_line_byte(c);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sender holds off until every queued verdict has come out.
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_fields(input logic [7:0] v);
    drain_verdicts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_fields = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CHR_ZERO + 8'(n);
    return (lower ? CHR_A_LO : CHR_A_UP) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  // Whitespace other than newline
  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return clfc_pkg::ChrSpace;
    if (r == 1) return CHR_TAB;
    return CHR_TAB + 8'(r);
  endfunction

  // Never blank, comma, star or newline
  function automatic logic [7:0] rand_field_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = CHR_ZERO + 8'($urandom_range(0, 9));
      1: c = CHR_A_UP + 8'($urandom_range(0, 25));
      2: c = CHR_DOT;
      3: c = CHR_DASH;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (blank_char(c) || c == clfc_pkg::ChrComma || c == clfc_pkg::ChrStar);
      end
    endcase
    return c;
  endfunction

  function automatic void load_payload(input string s);
    payload_q.delete();
    for (int i = 0; i < s.len(); i++) payload_q.push_back(s[i]);
  endfunction

  function automatic void make_payload(input int nfields, input bit with_stars);
    payload_q.delete();
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) payload_q.push_back(clfc_pkg::ChrComma);
      repeat ($urandom_range(0, 3)) payload_q.push_back(rand_field_char());
      if (with_stars && $urandom_range(0, 3) == 0) payload_q.push_back(clfc_pkg::ChrStar);
    end
  endfunction

  // Mostly empty fields, keeps very long field counts short on the wire
  function automatic void make_sparse_payload(input int nfields);
    payload_q.delete();
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) payload_q.push_back(clfc_pkg::ChrComma);
      if ($urandom_range(0, 15) == 0) payload_q.push_back(rand_field_char());
      if ($urandom_range(0, 15) == 0) payload_q.push_back(clfc_pkg::ChrStar);
    end
  endfunction

  // Well-formed line around payload_q: optional leading blanks, star, hex of
  // the payload CRC (one bit flipped when corrupt), optional trailing blanks.
  task automatic emit_frame(input bit corrupt);
    logic [15:0] crc;
    int          ndig;
    int          lead;
    int          trail;
    bit          lower;
    crc = clfc_pkg::CrcInit;
    foreach (payload_q[i]) crc = crc_ccitt_step(crc, payload_q[i]);
    if (corrupt) crc ^= 16'h0001 << $urandom_range(0, 15);
    ndig = $urandom_range(1, 4);
    while (ndig < 4 && (crc >> (4 * ndig)) != 0) ndig++;
    lower = $urandom_range(0, 1);
    lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (lead) send_byte(rand_blank());
    foreach (payload_q[i]) send_byte(payload_q[i]);
    send_byte(clfc_pkg::ChrStar);
    for (int i = ndig - 1; i >= 0; i--) send_byte(hex_char(crc[4*i +: 4], lower));
    repeat (trail) send_byte(rand_blank());
    send_byte(clfc_pkg::ChrNewline);
  endtask

  task automatic send_broken(input broken_e kind);
    make_payload($urandom_range(1, 4), 1'b0);
    foreach (payload_q[i]) send_byte(payload_q[i]);
    if (kind != BRK_NO_STAR) send_byte(clfc_pkg::ChrStar);
    case (kind)
      BRK_LONG_HEX: repeat ($urandom_range(5, 6)) send_byte(rand_hex_char());
      BRK_PREFIX: begin
        send_byte(CHR_ZERO);
        send_byte(CHR_X_LO);
        repeat (2) send_byte(rand_hex_char());
      end
      BRK_LEAD_SPACE: begin
        send_byte(clfc_pkg::ChrSpace);
        repeat (4) send_byte(rand_hex_char());
      end
      BRK_DIGIT_AFTER_SPACE: begin
        repeat (2) send_byte(rand_hex_char());
        send_byte(CHR_TAB);
        send_byte(rand_hex_char());
      end
      BRK_COMMA_IN_HEX: begin
        send_byte(rand_hex_char());
        send_byte(clfc_pkg::ChrComma);
        send_byte(rand_hex_char());
      end
      BRK_NON_HEX: begin
        send_byte(rand_hex_char());
        send_byte($urandom_range(0, 1) ? CHR_G_UP : CHR_DASH);
      end
      default: ;
    endcase
    send_byte(clfc_pkg::ChrNewline);
  endtask

  task automatic test_reset_field_count();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    make_payload(14, 1'b0);
    emit_frame(1'b0);
    make_payload(13, 1'b0);
    emit_frame(1'b0);
  endtask

  task automatic test_directed_lines();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_fields(8'd3);
    send_str("\n");
    send_str(" \t\r\n");
    load_payload("1,2,3");
    emit_frame(1'b0);
    load_payload("a,b,c");
    emit_frame(1'b0);
    load_payload("x,y,z");
    emit_frame(1'b1);
    load_payload("1,2");
    emit_frame(1'b0);
    // earlier stars belong to the payload
    load_payload("*a,b*,c");
    emit_frame(1'b0);
    load_payload("");
    emit_frame(1'b0);
    drain_verdicts();
    send_str("1,2,3\n");
    for (int k = BRK_NO_STAR; k <= BRK_NON_HEX; k++) send_broken(broken_e'(k));
    payload_q.delete();
    payload_q.push_back(8'h00);
    payload_q.push_back(clfc_pkg::ChrComma);
    payload_q.push_back(8'hFF);
    payload_q.push_back(clfc_pkg::ChrComma);
    payload_q.push_back(8'h7F);
    emit_frame(1'b0);
    send_str("  ,,*FFFF\r\n");
  endtask

  task automatic test_field_count_limits();
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    set_fields(8'd1);
    load_payload("abc");
    emit_frame(1'b0);
    make_payload(2, 1'b0);
    emit_frame(1'b0);
    set_fields(8'd255);
    make_sparse_payload(255);
    emit_frame(1'b0);
    // count saturates, so far more fields still match 255
    make_sparse_payload(300);
    emit_frame(1'b0);
    make_sparse_payload(254);
    emit_frame(1'b0);
    set_fields(FIELDS_AT_RESET);
  endtask

  task automatic random_line();
    int r;
    int nfields;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      nfields = ($urandom_range(0, 3) == 0) ? $urandom_range(1, exp_fields + 2) : exp_fields;
      make_payload(nfields, $urandom_range(0, 7) == 0);
      emit_frame($urandom_range(0, 9) == 0);
    end else if (r < 82) begin
      send_broken(broken_e'($urandom_range(BRK_NO_STAR, BRK_NON_HEX)));
    end else if (r < 88) begin
      repeat ($urandom_range(0, 3)) send_byte(rand_blank());
      send_byte(clfc_pkg::ChrNewline);
    end else begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_stream();
    int start_bytes;
    int chunk_end;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 4))
        0:       set_fields(8'd1);
        1:       set_fields(FIELDS_AT_RESET);
        2:       set_fields(8'($urandom_range(1, 8)));
        default: set_fields(8'($urandom_range(1, 40)));
      endcase
      {src_idle, sink_idle} = 2'($urandom_range(0, 3));
      chunk_end = bytes_sent + $urandom_range(100, 200);
      while (bytes_sent < chunk_end) begin
        random_line();
        if ($urandom_range(0, 39) == 0) drain_verdicts();
      end
    end
  endtask

  // Result side: random stall after each result while sink_idle is set, compare against the oldest verdict.
  initial begin
    int           stall;
    line_result_t want;
    m_axis_tready = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (verdicts_due.size() == 0) begin
          log_failure($sformatf("unexpected result, tdata %h", m_axis_tdata));
        end else begin
          want = verdicts_due.pop_front();
          // tdata: [2:0] verdict, [18:3] rx crc, [34:19] calc crc, [42:35] fields
          if (m_axis_tdata[2:0] !== want.verdict || m_axis_tdata[18:3] !== want.rx_crc ||
              m_axis_tdata[34:19] !== want.calc_crc || m_axis_tdata[42:35] !== want.fields)
            log_failure($sformatf(
              "mismatch exp/got: verdict %0d/%0d rx %h/%h calc %h/%h fields %0d/%0d",
              want.verdict, m_axis_tdata[2:0], want.rx_crc, m_axis_tdata[18:3],
              want.calc_crc, m_axis_tdata[34:19], want.fields, m_axis_tdata[42:35]));
        end
        stall = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      m_axis_tready <= (stall == 0);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    bytes_sent    = 0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    exp_fields    = FIELDS_AT_RESET;
    clear_line_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_field_count();
    test_directed_lines();
    test_field_count_limits();
    test_random_stream();

    drain_verdicts();
    if (verdicts_due.size() != 0)
      log_failure($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/clfc_pkg.sv
hdl/clfc_line_tracker.sv
hdl/crc16_line_frame_checker_unit.sv
tb/crc16_line_frame_checker_unit_tb.sv
